// File: sv/assert_macros.svh
// Assertion helpers shared by the sequencer modules.
// Every macro samples on i_clk and is held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every sampled edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/i2cbts_pkg.sv
package i2cbts_pkg;

    typedef enum logic [2:0] {
        KIND_BUF_WRITE  = 3'd0,
        KIND_BUF_READ   = 3'd1,
        KIND_START_SEND = 3'd2,
        KIND_START_RECV = 3'd3,
        KIND_START_REG  = 3'd4,
        KIND_DONE       = 3'd5
    } t_kind;

    typedef enum logic [3:0] {
        CMD_NONE        = 4'd0,
        CMD_SINGLE_SEND = 4'd1,
        CMD_SEND_START  = 4'd2,
        CMD_SEND_CONT   = 4'd3,
        CMD_SEND_FINISH = 4'd4,
        CMD_SINGLE_RECV = 4'd5,
        CMD_RECV_START  = 4'd6,
        CMD_RECV_CONT   = 4'd7,
        CMD_RECV_FINISH = 4'd8
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_SEND_NEXT = 3'd1,
        PH_SEND_LAST = 3'd2,
        PH_SEND_REG  = 3'd3,
        PH_AWAIT     = 3'd4,
        PH_RX_NEXT   = 3'd5,
        PH_RX_NTL    = 3'd6,
        PH_RX_LAST   = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        CS_IDLE = 2'd0,
        CS_EXEC = 2'd1,
        CS_HOLD = 2'd2
    } t_ctl_state;

    // Input item as taken from the slave-side beat.
    typedef struct packed {
        t_kind       kind;
        logic [6:0]  slave_address;
        logic [3:0]  byte_count;
        logic [2:0]  buffer_index;
        logic [7:0]  write_byte;
        logic [7:0]  received_byte;
    } t_item;

    typedef struct packed {
        t_cmd        command;
        logic        address_load;
        logic [6:0]  address_out;
        logic        read_not_write;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [7:0]  read_data;
        logic        transfer_done;
        logic        rejected;
        logic        busy_res;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } t_ctrl;

    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned S_TUSER_W = 3;
    localparam int unsigned M_TDATA_W = 40;

endpackage

// File: sv/i2c_burst_transaction_sequencer_unit.sv
// I2C burst transaction sequencer.
// Slave side: one beat per event. tuser carries the event kind (buffer write,
// buffer read, start send, start receive, start register read, master done);
// tdata carries the address, byte count, buffer index and data bytes.
// Master side: one beat per event with the command for the master core, the
// address load, the byte to transmit, read data and the done, rejected and
// busy flags.
// Every accepted event gives exactly one result beat. An event is captured in
// the cycle it is accepted, the buffer read issued then returns in the next
// cycle, where the event executes, and the result beat is offered from the
// cycle after that. One event is in flight at a time: tready is high only
// while no event is held, so the block takes no new event until the result
// beat of the last one has been taken. The registered read of the byte
// buffer and the held result beat are what keep an event in flight.
// A stalled master side holds the result beat unchanged and keeps tready low.
// Reset returns the sequencer to idle and makes every buffer entry read zero.
module i2c_burst_transaction_sequencer_unit #(
    parameter int BUFFER_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // kind[2:0]
    input  logic [2:0]  i_s_tuser,
    // slave_address[6:0], byte_count[10:7], buffer_index[13:11],
    // write_byte[21:14], received_byte[29:22], zero[31:30]
    input  logic [31:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // command[3:0], address_load[4], address_out[11:5], read_not_write[12],
    // tx_valid[13], tx_byte[21:14], read_data[29:22], transfer_done[30],
    // rejected[31], busy_res[32], zero[39:33]
    output logic [39:0] o_m_tdata
);

    i2cbts_pkg::t_ctrl   ctrl;
    i2cbts_pkg::t_item   item;
    i2cbts_pkg::t_result result;

    always_comb begin
        item.kind          = i2cbts_pkg::t_kind'(i_s_tuser);
        item.slave_address = i_s_tdata[6:0];
        item.byte_count    = i_s_tdata[10:7];
        item.buffer_index  = i_s_tdata[13:11];
        item.write_byte    = i_s_tdata[21:14];
        item.received_byte = i_s_tdata[29:22];
    end

    i2cbts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_ctrl     (ctrl)
    );

    i2cbts_dp #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_item   (item),
        .o_result (result)
    );

    assign o_m_tdata = {7'b0,
                        result.busy_res,
                        result.rejected,
                        result.transfer_done,
                        result.read_data,
                        result.tx_byte,
                        result.tx_valid,
                        result.read_not_write,
                        result.address_out,
                        result.address_load,
                        result.command};

endmodule

// File: sv/i2cbts_ram.sv
module i2cbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/i2cbts_ctrl.sv
`include "assert_macros.svh"

module i2cbts_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output i2cbts_pkg::t_ctrl  o_ctrl
);

    i2cbts_pkg::t_ctl_state r_state;
    i2cbts_pkg::t_ctl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i2cbts_pkg::CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_s_tready     = 1'b0;
        o_m_tvalid     = 1'b0;
        o_ctrl.capture = 1'b0;
        o_ctrl.execute = 1'b0;
        case (r_state)
            i2cbts_pkg::CS_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_ctrl.capture = 1'b1;
                    n_state        = i2cbts_pkg::CS_EXEC;
                end
            end
            i2cbts_pkg::CS_EXEC: begin
                o_ctrl.execute = 1'b1;
                n_state        = i2cbts_pkg::CS_HOLD;
            end
            i2cbts_pkg::CS_HOLD: begin
                o_m_tvalid = 1'b1;
                if (i_m_tready) begin
                    n_state = i2cbts_pkg::CS_IDLE;
                end
            end
            default: begin
                n_state = i2cbts_pkg::CS_IDLE;
            end
        endcase
    end

    `ASSERT_ALWAYS(a_one_side, !(o_s_tready && o_m_tvalid), "ready and valid overlap")
    `ASSERT_NEXT(a_capture_exec, o_ctrl.capture, o_ctrl.execute, "capture without execute")
    `ASSERT_NEXT(a_exec_valid, o_ctrl.execute, o_m_tvalid, "execute without result beat")

endmodule

// File: sv/i2cbts_dp.sv
`include "assert_macros.svh"

module i2cbts_dp #(
    parameter int BUFFER_BYTES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  i2cbts_pkg::t_ctrl    i_ctrl,
    input  i2cbts_pkg::t_item    i_item,
    output i2cbts_pkg::t_result  o_result
);

    localparam int AW = $clog2(BUFFER_BYTES);
    // Compare width: holds the depth itself and every 3-bit index or 4-bit count.
    localparam int PW = (AW + 1 > 4) ? AW + 1 : 4;
    localparam logic [PW-1:0] DEPTH_W = PW'(BUFFER_BYTES);

    i2cbts_pkg::t_item   r_item;
    i2cbts_pkg::t_phase  r_phase;
    i2cbts_pkg::t_phase  n_phase;
    logic [3:0]          r_remaining;
    logic [3:0]          n_remaining;
    logic [3:0]          r_ptr;
    logic [3:0]          n_ptr;
    logic [6:0]          r_target;
    logic [6:0]          n_target;
    logic [BUFFER_BYTES-1:0] r_valid;
    logic [AW-1:0]       r_raddr;
    i2cbts_pkg::t_result r_out;
    i2cbts_pkg::t_result n_out;

    logic [PW-1:0] rd_sel;
    logic [AW-1:0] rd_addr;
    logic [7:0]    ram_q;
    logic [7:0]    buf_q;
    logic          busy;
    logic          idx_ok;
    logic          cnt_bad;
    logic [PW-1:0] e_idx_w;
    logic [PW-1:0] e_ptr_w;
    logic [PW-1:0] cnt_w;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;

    function automatic i2cbts_pkg::t_phase rx_phase_for(input logic [3:0] n);
        i2cbts_pkg::t_phase ph;
        if (n == 4'd1) begin
            ph = i2cbts_pkg::PH_RX_LAST;
        end else if (n == 4'd2) begin
            ph = i2cbts_pkg::PH_RX_NTL;
        end else begin
            ph = i2cbts_pkg::PH_RX_NEXT;
        end
        return ph;
    endfunction

    // The buffer read is launched in the capture cycle, so the entry is ready
    // when the item executes in the cycle after.
    always_comb begin
        case (i_item.kind)
            i2cbts_pkg::KIND_BUF_READ: rd_sel = PW'(i_item.buffer_index);
            i2cbts_pkg::KIND_DONE:     rd_sel = PW'(r_ptr);
            default:                   rd_sel = '0;
        endcase
        rd_addr = rd_sel[AW-1:0];
    end

    i2cbts_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // Entries never written since reset read as zero.
    assign buf_q = r_valid[r_raddr] ? ram_q : 8'h00;

    always_comb begin
        busy        = r_phase != i2cbts_pkg::PH_IDLE;
        e_idx_w     = PW'(r_item.buffer_index);
        e_ptr_w     = PW'(r_ptr);
        cnt_w       = PW'(r_item.byte_count);
        idx_ok      = e_idx_w < DEPTH_W;
        cnt_bad     = (r_item.byte_count == 4'd0) || (cnt_w > DEPTH_W);
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_ptr       = r_ptr;
        n_target    = r_target;
        n_out       = '0;
        we          = 1'b0;
        waddr       = e_idx_w[AW-1:0];
        wdata       = r_item.write_byte;

        case (r_item.kind)
            i2cbts_pkg::KIND_BUF_WRITE: begin
                if (busy) begin
                    n_out.rejected = 1'b1;
                end else if (idx_ok) begin
                    we              = 1'b1;
                    n_out.read_data = r_item.write_byte;
                end
            end
            i2cbts_pkg::KIND_BUF_READ: begin
                if (idx_ok) begin
                    n_out.read_data = buf_q;
                end
            end
            i2cbts_pkg::KIND_START_SEND,
            i2cbts_pkg::KIND_START_RECV,
            i2cbts_pkg::KIND_START_REG: begin
                if (busy || cnt_bad) begin
                    n_out.rejected = 1'b1;
                end else begin
                    n_target           = r_item.slave_address;
                    n_out.address_load = 1'b1;
                    n_out.address_out  = r_item.slave_address;
                    n_ptr              = 4'd0;
                    if (r_item.kind == i2cbts_pkg::KIND_START_SEND) begin
                        n_out.tx_valid = 1'b1;
                        n_out.tx_byte  = buf_q;
                        n_ptr          = 4'd1;
                        n_remaining    = r_item.byte_count - 4'd1;
                        if (r_item.byte_count == 4'd1) begin
                            n_phase       = i2cbts_pkg::PH_AWAIT;
                            n_out.command = i2cbts_pkg::CMD_SINGLE_SEND;
                        end else begin
                            n_phase = (r_item.byte_count == 4'd2) ?
                                      i2cbts_pkg::PH_SEND_LAST : i2cbts_pkg::PH_SEND_NEXT;
                            n_out.command = i2cbts_pkg::CMD_SEND_START;
                        end
                    end else if (r_item.kind == i2cbts_pkg::KIND_START_RECV) begin
                        n_out.read_not_write = 1'b1;
                        n_remaining          = r_item.byte_count;
                        n_phase              = rx_phase_for(r_item.byte_count);
                        n_out.command        = (r_item.byte_count == 4'd1) ?
                                               i2cbts_pkg::CMD_SINGLE_RECV :
                                               i2cbts_pkg::CMD_RECV_START;
                    end else begin
                        // Register read: entry 0 goes out as the register address.
                        n_out.tx_valid = 1'b1;
                        n_out.tx_byte  = buf_q;
                        n_remaining    = r_item.byte_count;
                        n_phase        = i2cbts_pkg::PH_SEND_REG;
                        n_out.command  = i2cbts_pkg::CMD_SEND_START;
                    end
                end
            end
            i2cbts_pkg::KIND_DONE: begin
                case (r_phase)
                    i2cbts_pkg::PH_SEND_NEXT: begin
                        n_out.tx_valid = 1'b1;
                        n_out.tx_byte  = buf_q;
                        n_ptr          = r_ptr + 4'd1;
                        n_remaining    = r_remaining - 4'd1;
                        if (n_remaining == 4'd1) begin
                            n_phase = i2cbts_pkg::PH_SEND_LAST;
                        end
                        n_out.command = i2cbts_pkg::CMD_SEND_CONT;
                    end
                    i2cbts_pkg::PH_SEND_LAST: begin
                        n_out.tx_valid = 1'b1;
                        n_out.tx_byte  = buf_q;
                        n_out.command  = i2cbts_pkg::CMD_SEND_FINISH;
                        n_phase        = i2cbts_pkg::PH_AWAIT;
                    end
                    i2cbts_pkg::PH_AWAIT: begin
                        n_remaining         = 4'd0;
                        n_phase             = i2cbts_pkg::PH_IDLE;
                        n_out.transfer_done = 1'b1;
                    end
                    i2cbts_pkg::PH_SEND_REG: begin
                        n_out.address_load   = 1'b1;
                        n_out.address_out    = r_target;
                        n_out.read_not_write = 1'b1;
                        n_out.command        = (r_remaining == 4'd1) ?
                                               i2cbts_pkg::CMD_SINGLE_RECV :
                                               i2cbts_pkg::CMD_RECV_START;
                        n_phase              = rx_phase_for(r_remaining);
                    end
                    i2cbts_pkg::PH_RX_NEXT: begin
                        we              = 1'b1;
                        waddr           = e_ptr_w[AW-1:0];
                        wdata           = r_item.received_byte;
                        n_out.read_data = r_item.received_byte;
                        n_ptr           = r_ptr + 4'd1;
                        n_remaining     = r_remaining - 4'd1;
                        n_out.command   = i2cbts_pkg::CMD_RECV_CONT;
                        if (n_remaining == 4'd2) begin
                            n_phase = i2cbts_pkg::PH_RX_NTL;
                        end
                    end
                    i2cbts_pkg::PH_RX_NTL: begin
                        we              = 1'b1;
                        waddr           = e_ptr_w[AW-1:0];
                        wdata           = r_item.received_byte;
                        n_out.read_data = r_item.received_byte;
                        n_ptr           = r_ptr + 4'd1;
                        n_remaining     = r_remaining - 4'd1;
                        n_out.command   = i2cbts_pkg::CMD_RECV_FINISH;
                        n_phase         = i2cbts_pkg::PH_RX_LAST;
                    end
                    i2cbts_pkg::PH_RX_LAST: begin
                        we                  = 1'b1;
                        waddr               = e_ptr_w[AW-1:0];
                        wdata               = r_item.received_byte;
                        n_out.read_data     = r_item.received_byte;
                        n_remaining         = 4'd0;
                        n_phase             = i2cbts_pkg::PH_IDLE;
                        n_out.transfer_done = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        n_out.busy_res = n_phase != i2cbts_pkg::PH_IDLE;
        // Nothing is stored unless this cycle executes an item.
        if (!i_ctrl.execute) begin
            we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_item  <= i_item;
            r_raddr <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= i2cbts_pkg::PH_IDLE;
            r_remaining <= '0;
            r_ptr       <= '0;
            r_target    <= '0;
            r_valid     <= '0;
            r_out       <= '0;
        end else if (i_ctrl.execute) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_ptr       <= n_ptr;
            r_target    <= n_target;
            r_out       <= n_out;
            if (we) begin
                r_valid[waddr] <= 1'b1;
            end
        end
    end

    assign o_result = r_out;

    `ASSERT_IMPL(a_rej_quiet, r_out.rejected,
        (r_out.command == i2cbts_pkg::CMD_NONE) && !r_out.address_load,
        "rejected event issued a command")
    `ASSERT_IMPL(a_done_idle, r_out.transfer_done, !r_out.busy_res,
        "transfer done while still busy")
    `ASSERT_NEXT(a_busy_phase, i_ctrl.execute,
        r_out.busy_res == (r_phase != i2cbts_pkg::PH_IDLE),
        "busy flag disagrees with phase")

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int BUF_DEPTH = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_EVENTS = 1700;
    localparam int MAX_PRINTED = 40;
    // Kinds the sequencer does not decode.
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    typedef struct packed {
        i2cbts_pkg::t_cmd command;
        logic       address_load;
        logic [6:0] address_out;
        logic       read_not_write;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [7:0] read_data;
        logic       transfer_done;
        logic       rejected;
        logic       busy_res;
    } t_seq_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    // kind[2:0]
    logic [2:0]  i_s_tuser;
    // slave_address[6:0], byte_count[10:7], buffer_index[13:11],
    // write_byte[21:14], received_byte[29:22], zero[31:30]
    logic [31:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    // command[3:0], address_load[4], address_out[11:5], read_not_write[12],
    // tx_valid[13], tx_byte[21:14], read_data[29:22], transfer_done[30],
    // rejected[31], busy_res[32], zero[39:33]
    logic [39:0] o_m_tdata;

    bit sender_steady;
    bit receiver_steady;

    i2c_burst_transaction_sequencer_unit #(
        .BUFFER_BYTES(BUF_DEPTH)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tuser(i_s_tuser),
        .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata)
    );

    class burst_scoreboard;
        i2cbts_pkg::t_phase phase;
        logic [3:0] remaining;
        logic [6:0] pointer;
        logic [6:0] target;
        logic [7:0] buffer [BUF_DEPTH];
        t_seq_beat  pending_beats[$];
        int         error_count;

        function new();
            phase = i2cbts_pkg::PH_IDLE;
            remaining = '0;
            pointer = '0;
            target = '0;
            foreach (buffer[i]) buffer[i] = '0;
            error_count = 0;
        endfunction

        task report(string msg);
            if (error_count < MAX_PRINTED)
                $display("ERROR at %0t ns: %s", $realtime, msg);
            error_count++;
        endtask

        function bit is_busy();
            return phase != i2cbts_pkg::PH_IDLE;
        endfunction

        function int pending();
            return pending_beats.size();
        endfunction

        function logic [7:0] byte_at(int unsigned idx);
            return (idx < BUF_DEPTH) ? buffer[idx] : 8'h00;
        endfunction

        function void store_byte(int unsigned idx, logic [7:0] value);
            if (idx < BUF_DEPTH)
                buffer[idx] = value;
        endfunction

        function i2cbts_pkg::t_phase rx_phase_for(logic [3:0] n);
            if (n == 4'd1)
                return i2cbts_pkg::PH_RX_LAST;
            return (n == 4'd2) ? i2cbts_pkg::PH_RX_NTL : i2cbts_pkg::PH_RX_NEXT;
        endfunction

        // Advances the sequencer state by one accepted event and queues its beat.
        function void note_event(logic [2:0] kind, logic [31:0] data);
            logic [6:0] addr;
            logic [3:0] cnt;
            logic [2:0] idx;
            logic [7:0] wbyte;
            logic [7:0] rbyte;
            t_seq_beat  r;
            bit         was_busy;
            addr = data[6:0];
            cnt = data[10:7];
            idx = data[13:11];
            wbyte = data[21:14];
            rbyte = data[29:22];
            was_busy = is_busy();
            r = '0;
            r.command = i2cbts_pkg::CMD_NONE;
            case (kind)
                i2cbts_pkg::KIND_BUF_WRITE: begin
                    if (was_busy) begin
                        r.rejected = 1'b1;
                    end else if (idx < BUF_DEPTH) begin
                        store_byte(idx, wbyte);
                        r.read_data = wbyte;
                    end
                end
                i2cbts_pkg::KIND_BUF_READ: begin
                    r.read_data = byte_at(idx);
                end
                i2cbts_pkg::KIND_START_SEND, i2cbts_pkg::KIND_START_RECV,
                i2cbts_pkg::KIND_START_REG: begin
                    if (was_busy || cnt == 4'd0 || cnt > BUF_DEPTH) begin
                        r.rejected = 1'b1;
                    end else begin
                        target = addr;
                        r.address_load = 1'b1;
                        r.address_out = addr;
                        pointer = '0;
                        if (kind == i2cbts_pkg::KIND_START_SEND) begin
                            r.tx_valid = 1'b1;
                            r.tx_byte = byte_at(0);
                            pointer = 7'd1;
                            remaining = cnt - 4'd1;
                            if (cnt == 4'd1)
                                phase = i2cbts_pkg::PH_AWAIT;
                            else
                                phase = (cnt == 4'd2) ? i2cbts_pkg::PH_SEND_LAST :
                                                        i2cbts_pkg::PH_SEND_NEXT;
                            r.command = (cnt == 4'd1) ? i2cbts_pkg::CMD_SINGLE_SEND :
                                                        i2cbts_pkg::CMD_SEND_START;
                        end else if (kind == i2cbts_pkg::KIND_START_RECV) begin
                            r.read_not_write = 1'b1;
                            remaining = cnt;
                            phase = rx_phase_for(cnt);
                            r.command = (cnt == 4'd1) ? i2cbts_pkg::CMD_SINGLE_RECV :
                                                        i2cbts_pkg::CMD_RECV_START;
                        end else begin
                            // Register address goes out first, the read follows.
                            r.tx_valid = 1'b1;
                            r.tx_byte = byte_at(0);
                            remaining = cnt;
                            phase = i2cbts_pkg::PH_SEND_REG;
                            r.command = i2cbts_pkg::CMD_SEND_START;
                        end
                    end
                end
                i2cbts_pkg::KIND_DONE: begin
                    case (phase)
                        i2cbts_pkg::PH_SEND_NEXT: begin
                            r.tx_valid = 1'b1;
                            r.tx_byte = byte_at(pointer);
                            pointer = pointer + 7'd1;
                            remaining = remaining - 4'd1;
                            if (remaining == 4'd1)
                                phase = i2cbts_pkg::PH_SEND_LAST;
                            r.command = i2cbts_pkg::CMD_SEND_CONT;
                        end
                        i2cbts_pkg::PH_SEND_LAST: begin
                            r.tx_valid = 1'b1;
                            r.tx_byte = byte_at(pointer);
                            r.command = i2cbts_pkg::CMD_SEND_FINISH;
                            phase = i2cbts_pkg::PH_AWAIT;
                        end
                        i2cbts_pkg::PH_AWAIT: begin
                            remaining = '0;
                            phase = i2cbts_pkg::PH_IDLE;
                            r.transfer_done = 1'b1;
                        end
                        i2cbts_pkg::PH_SEND_REG: begin
                            r.address_load = 1'b1;
                            r.address_out = target;
                            r.read_not_write = 1'b1;
                            r.command = (remaining == 4'd1) ? i2cbts_pkg::CMD_SINGLE_RECV :
                                                              i2cbts_pkg::CMD_RECV_START;
                            phase = rx_phase_for(remaining);
                        end
                        i2cbts_pkg::PH_RX_NEXT: begin
                            store_byte(pointer, rbyte);
                            r.read_data = rbyte;
                            pointer = pointer + 7'd1;
                            remaining = remaining - 4'd1;
                            r.command = i2cbts_pkg::CMD_RECV_CONT;
                            if (remaining == 4'd2)
                                phase = i2cbts_pkg::PH_RX_NTL;
                        end
                        i2cbts_pkg::PH_RX_NTL: begin
                            store_byte(pointer, rbyte);
                            r.read_data = rbyte;
                            pointer = pointer + 7'd1;
                            remaining = remaining - 4'd1;
                            r.command = i2cbts_pkg::CMD_RECV_FINISH;
                            phase = i2cbts_pkg::PH_RX_LAST;
                        end
                        i2cbts_pkg::PH_RX_LAST: begin
                            store_byte(pointer, rbyte);
                            r.read_data = rbyte;
                            remaining = '0;
                            phase = i2cbts_pkg::PH_IDLE;
                            r.transfer_done = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
            r.busy_res = is_busy();
            pending_beats.push_back(r);
        endfunction

        task check_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
        endtask

        task check_result(logic [39:0] beat);
            t_seq_beat want;
            if (pending_beats.size() == 0) begin
                report($sformatf("result beat 0x%010h with nothing expected", beat));
                return;
            end
            want = pending_beats.pop_front();
            check_field("command", beat[3:0], want.command);
            check_field("address_load", beat[4], want.address_load);
            check_field("address_out", beat[11:5], want.address_out);
            check_field("read_not_write", beat[12], want.read_not_write);
            check_field("tx_valid", beat[13], want.tx_valid);
            check_field("tx_byte", beat[21:14], want.tx_byte);
            check_field("read_data", beat[29:22], want.read_data);
            check_field("transfer_done", beat[30], want.transfer_done);
            check_field("rejected", beat[31], want.rejected);
            check_field("busy_res", beat[32], want.busy_res);
        endtask
    endclass

    burst_scoreboard sb = new();

    always #5 i_clk = ~i_clk;

    initial i_clk = 1'b0;

    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata);
    end

    // Result side: random stalls before each beat, with stretches of none.
    initial begin
        int stall;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0)
                receiver_steady = !receiver_steady;
            stall = receiver_steady ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
        end
    end

    function automatic logic [31:0] pack_event(logic [6:0] addr, logic [3:0] cnt,
                                              logic [2:0] idx, logic [7:0] wbyte,
                                              logic [7:0] rbyte);
        return {2'b00, rbyte, wbyte, idx, cnt, addr};
    endfunction

    task automatic send_event(input logic [2:0] kind, input logic [31:0] data);
        int gap;
        if ($urandom_range(0, 49) == 0)
            sender_steady = !sender_steady;
        gap = sender_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= kind;
        i_s_tdata <= data;
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready));
        sb.note_event(kind, data);
    endtask

    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One event of a random walk through transfers: mostly well-formed
    // transactions, with rejected starts and writes and stray events mixed in.
    task automatic random_event(output bit ignored);
        logic [2:0] kind;
        logic [3:0] cnt;
        int         sel;
        sel = $urandom_range(0, 99);
        cnt = 4'($urandom_range(0, 15));
        ignored = 1'b0;
        if (!sb.is_busy()) begin
            if (sel < 25) begin
                kind = i2cbts_pkg::KIND_BUF_WRITE;
            end else if (sel < 32) begin
                kind = i2cbts_pkg::KIND_BUF_READ;
            end else if (sel < 82) begin
                kind = 3'($urandom_range(i2cbts_pkg::KIND_START_SEND,
                                         i2cbts_pkg::KIND_START_REG));
                cnt = 4'($urandom_range(1, BUF_DEPTH));
            end else if (sel < 90) begin
                kind = 3'($urandom_range(i2cbts_pkg::KIND_START_SEND,
                                         i2cbts_pkg::KIND_START_REG));
                cnt = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(BUF_DEPTH + 1, 15));
            end else if (sel < 95) begin
                kind = i2cbts_pkg::KIND_DONE;
                ignored = 1'b1;
            end else begin
                kind = $urandom_range(0, 1) ? KIND_SPARE_6 : KIND_SPARE_7;
                ignored = 1'b1;
            end
        end else begin
            if (sel < 75)
                kind = i2cbts_pkg::KIND_DONE;
            else if (sel < 82)
                kind = i2cbts_pkg::KIND_BUF_READ;
            else if (sel < 88)
                kind = i2cbts_pkg::KIND_BUF_WRITE;
            else if (sel < 95)
                kind = 3'($urandom_range(i2cbts_pkg::KIND_START_SEND,
                                         i2cbts_pkg::KIND_START_REG));
            else begin
                kind = $urandom_range(0, 1) ? KIND_SPARE_6 : KIND_SPARE_7;
                ignored = 1'b1;
            end
        end
        send_event(kind, pack_event(7'($urandom_range(0, 127)), cnt,
                                    3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255))));
    endtask

    initial begin
        int counted;
        bit ignored;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tuser = '0;
        i_s_tdata = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Buffer after reset, extreme writes, stray events while idle.
        send_event(i2cbts_pkg::KIND_BUF_READ, pack_event(7'h00, 4'd0, 3'd7, 8'h00, 8'h00));
        send_event(i2cbts_pkg::KIND_BUF_WRITE, pack_event(7'h00, 4'd0, 3'd0, 8'hFF, 8'h00));
        send_event(i2cbts_pkg::KIND_BUF_WRITE, pack_event(7'h7F, 4'hF, 3'd7, 8'h00, 8'hFF));
        send_event(i2cbts_pkg::KIND_BUF_WRITE, pack_event(7'h00, 4'd0, 3'd1, 8'h5A, 8'h00));
        send_event(i2cbts_pkg::KIND_DONE, pack_event(7'h00, 4'd0, 3'd0, 8'h00, 8'hFF));
        send_event(KIND_SPARE_6, pack_event(7'h7F, 4'hF, 3'd7, 8'hFF, 8'hFF));
        send_event(KIND_SPARE_7, pack_event(7'h7F, 4'hF, 3'd7, 8'hFF, 8'hFF));
        // Byte counts out of range.
        send_event(i2cbts_pkg::KIND_START_SEND, pack_event(7'h12, 4'd0, 3'd0, 8'h00, 8'h00));
        send_event(i2cbts_pkg::KIND_START_RECV, pack_event(7'h34, 4'd9, 3'd0, 8'h00, 8'h00));
        send_event(i2cbts_pkg::KIND_START_REG, pack_event(7'h7F, 4'hF, 3'd0, 8'h00, 8'h00));
        // Single-byte send.
        send_event(i2cbts_pkg::KIND_START_SEND, pack_event(7'h7F, 4'd1, 3'd0, 8'h00, 8'h00));
        send_event(i2cbts_pkg::KIND_DONE, pack_event(7'h00, 4'd0, 3'd0, 8'h00, 8'h00));
        // Register read of two bytes with busy-time start, write and read.
        send_event(i2cbts_pkg::KIND_START_REG, pack_event(7'h00, 4'd2, 3'd0, 8'h00, 8'h00));
        send_event(i2cbts_pkg::KIND_START_SEND, pack_event(7'h11, 4'd3, 3'd0, 8'h00, 8'h00));
        send_event(i2cbts_pkg::KIND_BUF_WRITE, pack_event(7'h00, 4'd0, 3'd2, 8'hC3, 8'h00));
        send_event(i2cbts_pkg::KIND_BUF_READ, pack_event(7'h00, 4'd0, 3'd0, 8'h00, 8'h00));
        send_event(i2cbts_pkg::KIND_DONE, pack_event(7'h00, 4'd0, 3'd0, 8'h00, 8'h3C));
        send_event(i2cbts_pkg::KIND_DONE, pack_event(7'h00, 4'd0, 3'd0, 8'h00, 8'hFF));
        send_event(i2cbts_pkg::KIND_DONE, pack_event(7'h00, 4'd0, 3'd0, 8'h00, 8'h00));
        // Single-byte receive.
        send_event(i2cbts_pkg::KIND_START_RECV, pack_event(7'h55, 4'd1, 3'd0, 8'h00, 8'h00));
        send_event(i2cbts_pkg::KIND_DONE, pack_event(7'h00, 4'd0, 3'd0, 8'h00, 8'hA5));
        // Three-byte send through continue and finish.
        send_event(i2cbts_pkg::KIND_START_SEND, pack_event(7'h2A, 4'd3, 3'd0, 8'h00, 8'h00));
        send_event(i2cbts_pkg::KIND_DONE, pack_event(7'h00, 4'd0, 3'd0, 8'h00, 8'h00));
        send_event(i2cbts_pkg::KIND_DONE, pack_event(7'h00, 4'd0, 3'd0, 8'h00, 8'h00));
        send_event(i2cbts_pkg::KIND_DONE, pack_event(7'h00, 4'd0, 3'd0, 8'h00, 8'h00));
        wait_for_results();

        counted = 0;
        while (counted < RANDOM_EVENTS) begin
            random_event(ignored);
            if (!ignored) begin
                counted++;
                // Let the result side empty out once in the middle of the run.
                if (counted == RANDOM_EVENTS / 2)
                    wait_for_results();
            end
        end
        wait_for_results();

        if (sb.error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
